>>> rtl/biquad_transposed_filter_core_macros.svh
// Assertion macros shared by the filter modules.
// Each expects clk and rst in scope; rst disables the check.
`ifndef BIQUAD_TRANSPOSED_FILTER_CORE_MACROS_SVH
`define BIQUAD_TRANSPOSED_FILTER_CORE_MACROS_SVH

// Same-cycle implication
`define BQT_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication
`define BQT_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/bqt_pkg.sv
package bqt_pkg;

  // Integer headroom bits of the state format above full scale
  localparam int GUARD_BITS = 4;

  // Configuration register indexes
  localparam int CFG_INDEX_BITS = 3;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_B0,
    CFG_B1,
    CFG_B2,
    CFG_A1,
    CFG_A2,
    CFG_FORM
  } cfg_index_t;

  // Request and form codes
  localparam logic REQ_FLUSH     = 1'b1;
  localparam logic FORM_FB_FIRST = 1'b0;

  // Multiplier lanes: one per coefficient
  localparam int NUM_LANES = 5;
  localparam int LANE_B0   = 0;
  localparam int LANE_B1   = 1;
  localparam int LANE_B2   = 2;
  localparam int LANE_NA1  = 3;
  localparam int LANE_NA2  = 4;

  // Lane groups started together
  localparam logic [NUM_LANES-1:0] START_ALL = 5'b11111;
  localparam logic [NUM_LANES-1:0] START_FF  = 5'b00111;
  localparam logic [NUM_LANES-1:0] START_FB  = 5'b11000;

  // Command to one multiplier lane
  typedef struct packed {
    logic start;
    logic coef_negate;
  } lane_cmd_t;

endpackage

>>> rtl/bqt_channels.sv
// Input channel: one request item
interface bqt_in_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, req_type, sample_in, input ready);
  modport sink   (input valid, req_type, sample_in, output ready);
endinterface

// Output channel: one filtered sample item
interface bqt_out_if #(parameter int SAMPLE_BITS = 24);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          clipped;

  modport source (output valid, sample_out, clipped, input ready);
  modport sink   (input valid, sample_out, clipped, output ready);
endinterface

>>> rtl/bqt_serial_mul.sv
`include "biquad_transposed_filter_core_macros.svh"

// Serial-parallel multiplier lane: state value times coefficient, one
// coefficient bit per cycle, then round half away from zero and saturate.
module bqt_serial_mul #(
  parameter int STATE_BITS     = 48,
  parameter int COEF_BITS      = 32,
  parameter int COEF_FRAC_BITS = 30
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bqt_pkg::lane_cmd_t           cmd,
  input  logic signed [STATE_BITS-1:0] a,
  input  logic        [COEF_BITS-1:0]  coef,
  output logic                         done,
  output logic signed [STATE_BITS-1:0] prod
);
  import bqt_pkg::*;

  localparam int PROD_BITS = STATE_BITS + COEF_BITS;
  localparam int RND_BITS  = PROD_BITS - COEF_FRAC_BITS;
  localparam int CMP_BITS  = (RND_BITS > STATE_BITS) ? RND_BITS : STATE_BITS;
  localparam int CNT_BITS  = $clog2(COEF_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(COEF_BITS - 1);
  localparam logic [CMP_BITS-1:0] LIM_POS  =
    CMP_BITS'({1'b0, {(STATE_BITS-1){1'b1}}});

  typedef enum logic [1:0] {L_IDLE, L_RUN, L_ROUND, L_FIN} lane_state_t;

  lane_state_t           state;
  logic [CNT_BITS-1:0]   cnt;
  logic [STATE_BITS-1:0] mag_a;
  logic [COEF_BITS-1:0]  cbits;
  logic [STATE_BITS-1:0] acc;
  logic [COEF_BITS-1:0]  lo;
  logic                  neg;
  logic [RND_BITS-1:0]   rmag;

  logic [STATE_BITS-1:0] a_mag;
  logic [COEF_BITS-1:0]  c_mag;
  logic [STATE_BITS:0]   step_sum;
  logic [PROD_BITS-1:0]  full;
  logic [RND_BITS-1:0]   rnd;
  logic [CMP_BITS-1:0]   lim;
  logic [CMP_BITS-1:0]   rmag_ext;
  logic [CMP_BITS-1:0]   sat_mag;
  logic [CMP_BITS-1:0]   signed_res;

  // Operand magnitudes at load
  assign a_mag = a[STATE_BITS-1] ? (~a + 1'b1) : a;
  assign c_mag = coef[COEF_BITS-1] ? (~coef + 1'b1) : coef;

  // Add-shift step, LSB of the coefficient first
  assign step_sum = {1'b0, acc} + (cbits[0] ? {1'b0, mag_a} : '0);

  // Round: adding half an LSB carries into the kept bits iff the bit below is set
  assign full = {acc, lo};
  assign rnd  = full[PROD_BITS-1:COEF_FRAC_BITS] + RND_BITS'(full[COEF_FRAC_BITS-1]);

  // Saturate magnitude (one more for negative results), then apply the sign
  assign lim        = LIM_POS + CMP_BITS'(neg);
  assign rmag_ext   = CMP_BITS'(rmag);
  assign sat_mag    = (rmag_ext > lim) ? lim : rmag_ext;
  assign signed_res = neg ? (~sat_mag + 1'b1) : sat_mag;

  // Lane sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (cmd.start) begin
            mag_a <= a_mag;
            cbits <= c_mag;
            acc   <= '0;
            lo    <= '0;
            neg   <= a[STATE_BITS-1] ^ coef[COEF_BITS-1] ^ cmd.coef_negate;
            cnt   <= '0;
            state <= L_RUN;
          end
        end
        L_RUN: begin
          acc   <= step_sum[STATE_BITS:1];
          lo    <= {step_sum[0], lo[COEF_BITS-1:1]};
          cbits <= cbits >> 1;
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= L_ROUND;
          end
        end
        L_ROUND: begin
          rmag  <= rnd;
          state <= L_FIN;
        end
        L_FIN: begin
          prod  <= signed_res[STATE_BITS-1:0];
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: begin
          state <= L_IDLE;
        end
      endcase
    end
  end

  `BQT_ASSERT_IMPLY(a_start_idle, cmd.start, state == L_IDLE, "lane started while busy")
  `BQT_ASSERT_NEXT(a_done_pulse, done, !done, "lane done held for more than one cycle")
  `BQT_ASSERT_IMPLY(a_sign_ok, done && !neg, !prod[STATE_BITS-1], "positive product came out negative")

endmodule

>>> rtl/bqt_out_round.sv
// Output stage: round the state-format result to a sample, saturate,
// and hold it in the output register until taken.
module bqt_out_round #(
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS  = 48,
  parameter int FRAC_BITS   = 20
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  logic signed [STATE_BITS-1:0] y,
  output logic                         can_load,
  bqt_out_if.source                    rsp
);

  localparam int SHR_BITS = STATE_BITS - FRAC_BITS;
  localparam logic [STATE_BITS:0] HALF = (STATE_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                         out_valid;
  logic [SAMPLE_BITS-1:0]       out_sample;
  logic                         out_clip;

  logic [STATE_BITS:0]          sum;
  logic [STATE_BITS-1:0]        ysat;
  logic [SHR_BITS-1:0]          shifted;
  logic [SHR_BITS-SAMPLE_BITS:0] top_bits;
  logic                         fits;
  logic [SAMPLE_BITS-1:0]       val;

  // Add half an LSB with state saturation, then floor shift
  assign sum = {y[STATE_BITS-1], y} + HALF;
  always_comb begin
    if (sum[STATE_BITS] != sum[STATE_BITS-1]) begin
      ysat = sum[STATE_BITS] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                             : {1'b0, {(STATE_BITS-1){1'b1}}};
    end else begin
      ysat = sum[STATE_BITS-1:0];
    end
  end
  assign shifted = ysat[STATE_BITS-1:FRAC_BITS];

  // Clamp to sample range
  assign top_bits = shifted[SHR_BITS-1:SAMPLE_BITS-1];
  assign fits     = (&top_bits) | ~(|top_bits);
  assign val      = fits ? shifted[SAMPLE_BITS-1:0]
                         : (shifted[SHR_BITS-1] ? SMP_MIN : SMP_MAX);

  assign can_load = !out_valid || rsp.ready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid  <= 1'b1;
      out_sample <= val;
      out_clip   <= !fits;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.sample_out = out_sample;
  assign rsp.clipped    = out_clip;

endmodule

>>> rtl/biquad_transposed_filter_core.sv
// Channel  Dir  Fields                  Accepted when
// req      in   req_type, sample_in     req.valid && req.ready
// rsp      out  sample_out, clipped     rsp.valid && rsp.ready
// cfg      in   cfg_index, cfg_data     cfg_we
//
// A filter item runs through the bit-serial multiplier lanes: one coefficient
// bit per cycle, all five lanes in parallel in form 0, two passes in form 1.
// A flush clears the delay state while the core stays idle.
// Synchronous reset clears the delay state and loads register defaults.
// The output register frees the core while a result waits; a new item
// stalls only when that register is still full at the end of the next one.
`include "biquad_transposed_filter_core_macros.svh"

module biquad_transposed_filter_core #(
  parameter int SAMPLE_BITS    = 24,
  parameter int COEF_BITS      = 32,
  parameter int COEF_FRAC_BITS = 30,
  parameter int STATE_BITS     = 48
) (
  input  logic                                  clk,
  input  logic                                  rst,
  bqt_in_if.sink                                req,
  bqt_out_if.source                             rsp,
  input  logic                                  cfg_we,
  input  logic [bqt_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COEF_BITS-1:0]                  cfg_data
);
  import bqt_pkg::*;

  localparam int STATE_FRAC_BITS = STATE_BITS - SAMPLE_BITS - GUARD_BITS;
  localparam logic [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_WSUM, S_START_A, S_WAIT_A, S_UPD0,
    S_Y1, S_WAIT_B, S_SUM_A, S_SUM_B, S_OUT
  } core_state_t;

  core_state_t state;

  // Configuration registers
  logic [COEF_BITS-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic                 form_sel;

  // Delay state and working registers
  logic signed [STATE_BITS-1:0] fb_delay_one, fb_delay_two;
  logic signed [STATE_BITS-1:0] ff_delay_one, ff_delay_two;
  logic signed [STATE_BITS-1:0] opnd, y_reg, tmp;
  logic [NUM_LANES-1:0]         lane_start;

  // Lane wiring
  lane_cmd_t                    lane_cmd  [NUM_LANES];
  logic signed [STATE_BITS-1:0] lane_a    [NUM_LANES];
  logic [COEF_BITS-1:0]         lane_coef [NUM_LANES];
  logic signed [STATE_BITS-1:0] lane_prod [NUM_LANES];
  logic [NUM_LANES-1:0]         lane_done;

  logic signed [STATE_BITS-1:0] x_ext;
  logic [NUM_LANES-1:0]         mask_a;
  logic                         grp_a_done, grp_b_done;
  logic                         out_can_load, out_load;

  // Saturating add in state format
  function automatic logic signed [STATE_BITS-1:0] sat_add(
    input logic signed [STATE_BITS-1:0] p,
    input logic signed [STATE_BITS-1:0] q
  );
    logic [STATE_BITS:0] s;
    s = {p[STATE_BITS-1], p} + {q[STATE_BITS-1], q};
    if (s[STATE_BITS] != s[STATE_BITS-1]) begin
      sat_add = s[STATE_BITS] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                              : {1'b0, {(STATE_BITS-1){1'b1}}};
    end else begin
      sat_add = s[STATE_BITS-1:0];
    end
  endfunction

  // Sample into state format
  assign x_ext = {{GUARD_BITS{req.sample_in[SAMPLE_BITS-1]}}, req.sample_in,
                  {STATE_FRAC_BITS{1'b0}}};

  assign req.ready = (state == S_IDLE);

  // Lane operands: b lanes take w or x, feedback lanes take w or y
  always_comb begin
    lane_coef[LANE_B0]  = coef_b0;
    lane_coef[LANE_B1]  = coef_b1;
    lane_coef[LANE_B2]  = coef_b2;
    lane_coef[LANE_NA1] = coef_a1;
    lane_coef[LANE_NA2] = coef_a2;
    lane_a[LANE_B0]     = opnd;
    lane_a[LANE_B1]     = opnd;
    lane_a[LANE_B2]     = opnd;
    lane_a[LANE_NA1]    = (form_sel == FORM_FB_FIRST) ? opnd : y_reg;
    lane_a[LANE_NA2]    = (form_sel == FORM_FB_FIRST) ? opnd : y_reg;
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_cmd[i].start       = lane_start[i];
      lane_cmd[i].coef_negate = (i >= LANE_NA1);
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bqt_serial_mul #(
      .STATE_BITS     (STATE_BITS),
      .COEF_BITS      (COEF_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_lane (
      .clk  (clk),
      .rst  (rst),
      .cmd  (lane_cmd[g]),
      .a    (lane_a[g]),
      .coef (lane_coef[g]),
      .done (lane_done[g]),
      .prod (lane_prod[g])
    );
  end

  // Lane group completion
  assign mask_a     = (form_sel == FORM_FB_FIRST) ? START_ALL : START_FF;
  assign grp_a_done = ((lane_done & mask_a) == mask_a);
  assign grp_b_done = ((lane_done & START_FB) == START_FB);

  assign out_load = (state == S_OUT) && out_can_load;

  bqt_out_round #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .STATE_BITS  (STATE_BITS),
    .FRAC_BITS   (STATE_FRAC_BITS)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (out_load),
    .y        (y_reg),
    .can_load (out_can_load),
    .rsp      (rsp)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0  <= B0_RESET;
      coef_b1  <= '0;
      coef_b2  <= '0;
      coef_a1  <= '0;
      coef_a2  <= '0;
      form_sel <= FORM_FB_FIRST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_B0:   coef_b0  <= cfg_data;
        CFG_B1:   coef_b1  <= cfg_data;
        CFG_B2:   coef_b2  <= cfg_data;
        CFG_A1:   coef_a1  <= cfg_data;
        CFG_A2:   coef_a2  <= cfg_data;
        CFG_FORM: form_sel <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  // Item sequencer and delay state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lane_start   <= '0;
      fb_delay_one <= '0;
      fb_delay_two <= '0;
      ff_delay_one <= '0;
      ff_delay_two <= '0;
    end else begin
      lane_start <= '0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.req_type == REQ_FLUSH) begin
              fb_delay_one <= '0;
              fb_delay_two <= '0;
              ff_delay_one <= '0;
              ff_delay_two <= '0;
            end else begin
              opnd  <= x_ext;
              state <= (form_sel == FORM_FB_FIRST) ? S_WSUM : S_START_A;
            end
          end
        end
        S_WSUM: begin
          opnd  <= sat_add(fb_delay_one, opnd);
          state <= S_START_A;
        end
        S_START_A: begin
          lane_start <= mask_a;
          state      <= S_WAIT_A;
        end
        S_WAIT_A: begin
          if (grp_a_done) begin
            state <= (form_sel == FORM_FB_FIRST) ? S_UPD0 : S_Y1;
          end
        end
        S_UPD0: begin
          y_reg        <= sat_add(lane_prod[LANE_B0], ff_delay_one);
          fb_delay_one <= sat_add(lane_prod[LANE_NA1], fb_delay_two);
          fb_delay_two <= lane_prod[LANE_NA2];
          ff_delay_one <= sat_add(lane_prod[LANE_B1], ff_delay_two);
          ff_delay_two <= lane_prod[LANE_B2];
          state        <= S_OUT;
        end
        S_Y1: begin
          y_reg      <= sat_add(lane_prod[LANE_B0], ff_delay_one);
          lane_start <= START_FB;
          state      <= S_WAIT_B;
        end
        S_WAIT_B: begin
          if (grp_b_done) begin
            state <= S_SUM_A;
          end
        end
        S_SUM_A: begin
          tmp   <= sat_add(lane_prod[LANE_NA1], lane_prod[LANE_B1]);
          state <= S_SUM_B;
        end
        S_SUM_B: begin
          ff_delay_one <= sat_add(tmp, ff_delay_two);
          ff_delay_two <= sat_add(lane_prod[LANE_NA2], lane_prod[LANE_B2]);
          state        <= S_OUT;
        end
        S_OUT: begin
          if (out_can_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BQT_ASSERT_IMPLY(a_done_in_wait, |lane_done, (state == S_WAIT_A) || (state == S_WAIT_B), "lane finished outside a wait state")
  `BQT_ASSERT_IMPLY(a_lanes_together, (state == S_WAIT_A) && (form_sel == FORM_FB_FIRST) && lane_done[LANE_B0], &lane_done, "lanes out of step")
  `BQT_ASSERT_NEXT(a_flush_clears, req.valid && req.ready && (req.req_type == REQ_FLUSH), (ff_delay_one == '0) && (fb_delay_one == '0) && (state == S_IDLE), "flush left state behind")

endmodule
